// ===== rtl/frx_pkg.sv =====
// package for the framed packet receiver
// event codes, register indexes, configuration struct and the crc-16 byte update
package frx_pkg;

  localparam int unsigned HdrBytesDefault = 80;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam int unsigned CfgAddrWidth = 5;

  typedef enum logic [2:0] {
    EV_START       = 3'd0,
    EV_STORED      = 3'd1,
    EV_ACK_COMMIT  = 3'd2,
    EV_ACK_PRELOAD = 3'd3,
    EV_NAK_CRC     = 3'd4,
    EV_ERR_HEADER  = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    REG_MAGIC       = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_FRAME_LIMIT = 3'd3,
    REG_FRAME_LEN   = 3'd4,
    REG_MAX_PACKET  = 3'd5,
    REG_VERSION     = 3'd6,
    REG_NEXT        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [23:0] magic_word;
    logic [15:0] req_width;
    logic [15:0] req_height;
    logic [15:0] frame_limit;
    logic [15:0] bytes_per_frame;
    logic [23:0] max_packet_bytes;
    logic [7:0]  version_flag;
    logic [7:0]  next_flag;
    logic [15:0] magic_crc;
  } cfg_t;

  // msb-first crc-16, poly 0x1021, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/frx_cfg_regs.sv =====
// apb register file of the framed packet receiver
// depends on frx_pkg for register indexes and the configuration struct
module frx_cfg_regs
  import frx_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  logic [23:0] magic_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  logic [15:0] frame_limit_q;
  logic [15:0] frame_len_q;
  logic [23:0] max_packet_q;
  logic [7:0]  version_q;
  logic [7:0]  next_q;
  logic [15:0] magic_crc_q;
  logic [15:0] magic_crc_d;
  logic        wr_en;
  reg_idx_e    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[CfgAddrWidth-1:2]);

  // crc state after the three sync bytes
  assign magic_crc_d = crc_byte(crc_byte(crc_byte(CrcInit, magic_q[23:16]),
                                         magic_q[15:8]), magic_q[7:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q       <= 24'd4608589;
      width_q       <= 16'd64;
      height_q      <= 16'd32;
      frame_limit_q <= 16'd64;
      frame_len_q   <= 16'd4096;
      max_packet_q  <= 24'd2097152;
      version_q     <= 8'd1;
      next_q        <= 8'd2;
      magic_crc_q   <= CrcInit;
    end else begin
      magic_crc_q <= magic_crc_d;
      if (wr_en) begin
        case (idx)
          REG_MAGIC:       magic_q       <= pwdata[23:0];
          REG_WIDTH:       width_q       <= pwdata[15:0];
          REG_HEIGHT:      height_q      <= pwdata[15:0];
          REG_FRAME_LIMIT: frame_limit_q <= pwdata[15:0];
          REG_FRAME_LEN:   frame_len_q   <= pwdata[15:0];
          REG_MAX_PACKET:  max_packet_q  <= pwdata[23:0];
          REG_VERSION:     version_q     <= pwdata[7:0];
          REG_NEXT:        next_q        <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_MAGIC:       prdata = {8'd0, magic_q};
      REG_WIDTH:       prdata = {16'd0, width_q};
      REG_HEIGHT:      prdata = {16'd0, height_q};
      REG_FRAME_LIMIT: prdata = {16'd0, frame_limit_q};
      REG_FRAME_LEN:   prdata = {16'd0, frame_len_q};
      REG_MAX_PACKET:  prdata = {8'd0, max_packet_q};
      REG_VERSION:     prdata = {24'd0, version_q};
      REG_NEXT:        prdata = {24'd0, next_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.magic_word       = magic_q;
  assign cfg_o.req_width        = width_q;
  assign cfg_o.req_height       = height_q;
  assign cfg_o.frame_limit      = frame_limit_q;
  assign cfg_o.bytes_per_frame  = frame_len_q;
  assign cfg_o.max_packet_bytes = max_packet_q;
  assign cfg_o.version_flag     = version_q;
  assign cfg_o.next_flag        = next_q;
  assign cfg_o.magic_crc        = magic_crc_q;

endmodule

// ===== rtl/frx_deframer.sv =====
// byte deframer: input register, receive state machine with crc, result register
// depends on frx_pkg for event codes, the configuration struct and crc_byte
module frx_deframer
  import frx_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HdrBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  data_byte_o,
  output logic [23:0] offset_o,
  output logic        slot_o,
  output logic [15:0] frame_count_o
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_H   = 3'd3,
    PH_CRC_L   = 3'd4
  } phase_e;

  localparam logic [23:0] HdrLast   = 24'(HEADER_BYTES - 1);
  localparam logic [23:0] HdrLen    = 24'(HEADER_BYTES);
  localparam logic [33:0] HdrCrcLen = 34'(HEADER_BYTES + 2);
  localparam logic [23:0] OffFlags  = 24'd3;
  localparam logic [23:0] OffFrmHi  = 24'd4;
  localparam logic [23:0] OffFrmLo  = 24'd5;
  localparam logic [23:0] OffWidHi  = 24'd6;
  localparam logic [23:0] OffWidLo  = 24'd7;
  localparam logic [23:0] OffHgtHi  = 24'd8;
  localparam logic [23:0] OffHgtLo  = 24'd9;
  localparam logic [23:0] OffLen0   = 24'd12;
  localparam logic [23:0] OffLen1   = 24'd13;
  localparam logic [23:0] OffLen2   = 24'd14;
  localparam logic [23:0] OffLen3   = 24'd15;
  localparam logic [23:0] OffMagic  = 24'd3;

  logic        in_vld_q, in_vld_d;
  logic [7:0]  in_byte_q, in_byte_d;
  phase_e      phase_q, phase_d;
  logic [23:0] window_q, window_d;
  logic [23:0] idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        fill_q, fill_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] frames_q, frames_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [23:0] last_pos_q, last_pos_d;
  logic [31:0] prod_q, prod_d;
  logic        out_vld_q, out_vld_d;
  event_e      ev_q, ev_d;
  logic [7:0]  data_q, data_d;
  logic [23:0] off_q, off_d;
  logic        slot_q, slot_d;
  logic [15:0] fc_q, fc_d;

  logic        advance;
  logic [7:0]  b;
  logic [15:0] crc_step;
  logic [23:0] win;
  logic        hdr_good;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign b          = in_byte_q;
  assign crc_step   = crc_byte(crc_q, b);
  assign win        = {window_q[15:0], b};
  assign prod_d     = {16'd0, frames_q} * {16'd0, cfg_i.bytes_per_frame};

  always_comb begin
    in_vld_d   = in_vld_q;
    in_byte_d  = in_byte_q;
    phase_d    = phase_q;
    window_d   = window_q;
    idx_d      = idx_q;
    crc_d      = crc_q;
    fill_d     = fill_q;
    flags_d    = flags_q;
    frames_d   = frames_q;
    width_d    = width_q;
    height_d   = height_q;
    len_d      = len_q;
    crc_hi_d   = crc_hi_q;
    last_pos_d = last_pos_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    ev_d       = ev_q;
    data_d     = data_q;
    off_d      = off_q;
    slot_d     = slot_q;
    fc_d       = fc_q;
    hdr_good   = 1'b0;

    if (in_valid_i && in_ready_o) begin
      in_vld_d  = 1'b1;
      in_byte_d = rx_byte_i;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end

    if (advance) begin
      data_d = b;
      off_d  = idx_q;
      slot_d = fill_q;
      fc_d   = 16'd0;
      ev_d   = EV_STORED;
      case (phase_q)
        PH_HEADER: begin
          case (idx_q)
            OffFlags: flags_d  = b;
            OffFrmHi: frames_d = {b, 8'd0};
            OffFrmLo: frames_d = {frames_q[15:8], b};
            OffWidHi: width_d  = {b, 8'd0};
            OffWidLo: width_d  = {width_q[15:8], b};
            OffHgtHi: height_d = {b, 8'd0};
            OffHgtLo: height_d = {height_q[15:8], b};
            OffLen0:  len_d    = {24'd0, b};
            OffLen1, OffLen2, OffLen3: len_d = {len_q[23:0], b};
            default: ;
          endcase
          crc_d     = crc_step;
          idx_d     = idx_q + 24'd1;
          out_vld_d = 1'b1;
          if (idx_q == HdrLast) begin
            hdr_good = (width_d == cfg_i.req_width) &&
                       (height_d == cfg_i.req_height) &&
                       (frames_d != 16'd0) && (frames_d <= cfg_i.frame_limit) &&
                       (len_d == prod_q) &&
                       (({2'd0, len_d} + HdrCrcLen) <= {10'd0, cfg_i.max_packet_bytes}) &&
                       ((flags_d == cfg_i.version_flag) || (flags_d == cfg_i.next_flag));
            if (!hdr_good) begin
              phase_d = PH_IDLE;
              idx_d   = 24'd0;
              ev_d    = EV_ERR_HEADER;
              fc_d    = frames_d;
            end else begin
              phase_d    = (len_d == 32'd0) ? PH_CRC_H : PH_PAYLOAD;
              last_pos_d = HdrLen + len_d[23:0] - 24'd1;
            end
          end
        end
        PH_PAYLOAD: begin
          crc_d     = crc_step;
          idx_d     = idx_q + 24'd1;
          out_vld_d = 1'b1;
          if (idx_q == last_pos_q) begin
            phase_d = PH_CRC_H;
          end
        end
        PH_CRC_H: begin
          crc_hi_d  = b;
          idx_d     = idx_q + 24'd1;
          phase_d   = PH_CRC_L;
          out_vld_d = 1'b1;
        end
        PH_CRC_L: begin
          phase_d   = PH_IDLE;
          idx_d     = 24'd0;
          out_vld_d = 1'b1;
          fc_d      = frames_q;
          if ({crc_hi_q, b} != crc_q) begin
            ev_d = EV_NAK_CRC;
          end else if (flags_q == cfg_i.next_flag) begin
            ev_d = EV_ACK_PRELOAD;
          end else begin
            ev_d   = EV_ACK_COMMIT;
            fill_d = !fill_q;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          if (win != cfg_i.magic_word) begin
            window_d = win;
          end else begin
            window_d  = 24'd0;
            crc_d     = cfg_i.magic_crc;
            idx_d     = OffMagic;
            phase_d   = PH_HEADER;
            out_vld_d = 1'b1;
            ev_d      = EV_START;
            off_d     = 24'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      in_byte_q  <= 8'd0;
      phase_q    <= PH_IDLE;
      window_q   <= 24'd0;
      idx_q      <= 24'd0;
      crc_q      <= CrcInit;
      fill_q     <= 1'b0;
      flags_q    <= 8'd0;
      frames_q   <= 16'd0;
      width_q    <= 16'd0;
      height_q   <= 16'd0;
      len_q      <= 32'd0;
      crc_hi_q   <= 8'd0;
      last_pos_q <= 24'd0;
      prod_q     <= 32'd0;
      out_vld_q  <= 1'b0;
      ev_q       <= EV_START;
      data_q     <= 8'd0;
      off_q      <= 24'd0;
      slot_q     <= 1'b0;
      fc_q       <= 16'd0;
    end else begin
      in_vld_q   <= in_vld_d;
      in_byte_q  <= in_byte_d;
      phase_q    <= phase_d;
      window_q   <= window_d;
      idx_q      <= idx_d;
      crc_q      <= crc_d;
      fill_q     <= fill_d;
      flags_q    <= flags_d;
      frames_q   <= frames_d;
      width_q    <= width_d;
      height_q   <= height_d;
      len_q      <= len_d;
      crc_hi_q   <= crc_hi_d;
      last_pos_q <= last_pos_d;
      prod_q     <= prod_d;
      out_vld_q  <= out_vld_d;
      ev_q       <= ev_d;
      data_q     <= data_d;
      off_q      <= off_d;
      slot_q     <= slot_d;
      fc_q       <= fc_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign event_res_o   = ev_q;
  assign data_byte_o   = data_q;
  assign offset_o      = off_q;
  assign slot_o        = slot_q;
  assign frame_count_o = fc_q;

endmodule

// ===== rtl/framed_packet_receiver_crc16_unit.sv =====
// framed packet receiver with crc-16 check: an input item accepted into the input register
// has its result item computed by the state machine and held in the output register
// throughput is one byte per cycle while the output is not stalled
// a stalled output holds the result and the input register, one item deep
// reset returns to sync search, clears the fill slot and restores register defaults
// depends on frx_pkg, frx_cfg_regs and frx_deframer
module framed_packet_receiver_crc16_unit
  import frx_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = HdrBytesDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              rx_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              event_res_o,
  output logic [7:0]              data_byte_o,
  output logic [23:0]             offset_o,
  output logic                    slot_o,
  output logic [15:0]             frame_count_o
);

  cfg_t cfg;

  frx_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  frx_deframer #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_deframer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .data_byte_o   (data_byte_o),
    .offset_o      (offset_o),
    .slot_o        (slot_o),
    .frame_count_o (frame_count_o)
  );

endmodule

// ===== rtl/frx_checker.sv =====
// port-level checks for the framed packet receiver and their bind to the top level
// depends on frx_pkg for event codes
module frx_checker
  import frx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_res_o,
  input logic [7:0]  data_byte_o,
  input logic [23:0] offset_o,
  input logic        slot_o,
  input logic [15:0] frame_count_o
);

  // a stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_res_o) &&
    $stable(data_byte_o) && $stable(offset_o) && $stable(slot_o) && $stable(frame_count_o))
    else $error("result item changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_res_o == EV_START) || (event_res_o == EV_STORED) ||
    (event_res_o == EV_ACK_COMMIT) || (event_res_o == EV_ACK_PRELOAD) ||
    (event_res_o == EV_NAK_CRC) || (event_res_o == EV_ERR_HEADER))
    else $error("undefined event code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_START) |-> (offset_o == 24'd0) && (frame_count_o == 16'd0))
    else $error("start event with nonzero offset or frame count");

  // a stored byte never lands on the magic offsets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_STORED) |-> (offset_o >= 24'd3) && (frame_count_o == 16'd0))
    else $error("stored byte item malformed");

endmodule

bind framed_packet_receiver_crc16_unit frx_checker u_frx_checker (.*);

// ===== test/framed_packet_receiver_crc16_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench for framed_packet_receiver_crc16_unit: framed packets, noise and broken frames
// are streamed in and every result item is checked against a behavioral deframer
// depends on frx_pkg and the receiver rtl
module framed_packet_receiver_crc16_unit_tb
  import frx_pkg::*;
();

  localparam int unsigned HdrLen = HdrBytesDefault;
  localparam logic [15:0] Poly = 16'h1021;

  typedef enum logic [2:0] {
    RX_IDLE, RX_HDR, RX_BODY, RX_CRC_HI, RX_CRC_LO
  } rx_phase_e;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  data;
    logic [23:0] off;
    logic        slot;
    logic [15:0] frames;
  } rx_event_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              rx_byte = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [2:0]              event_res;
  logic [7:0]              data_byte;
  logic [23:0]             offset;
  logic                    slot;
  logic [15:0]             frame_count;

  logic [23:0] cfg_magic;
  logic [15:0] cfg_width;
  logic [15:0] cfg_height;
  logic [15:0] cfg_frame_limit;
  logic [15:0] cfg_frame_len;
  logic [23:0] cfg_max_pkt;
  logic [7:0]  cfg_version;
  logic [7:0]  cfg_next;

  rx_phase_e   ph;
  logic [23:0] sync_win;
  logic [23:0] byte_idx;
  logic [15:0] crc_acc;
  logic        fill_slot;
  logic [7:0]  hdr_flags;
  logic [15:0] hdr_frames;
  logic [15:0] hdr_width;
  logic [15:0] hdr_height;
  logic [31:0] hdr_plen;
  logic [7:0]  crc_hi;

  logic [7:0]  byte_q[$];
  rx_event_t   rx_events_due[$];
  rx_event_t   due;
  int unsigned fail_cnt = 0;
  int unsigned src_idle_pct = 17;
  int unsigned sink_idle_pct = 17;
  bit          hold_arm = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left = 0;

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? Poly : 16'h0000);
    end
    return c;
  endfunction

  function automatic bit header_ok();
    longint unsigned need_len;
    longint unsigned total;
    need_len = 64'(hdr_frames) * 64'(cfg_frame_len);
    total = 64'(HdrLen) + 64'(hdr_plen) + 64'd2;
    return hdr_width == cfg_width && hdr_height == cfg_height &&
           hdr_frames != 16'd0 && hdr_frames <= cfg_frame_limit &&
           hdr_plen == need_len && total <= cfg_max_pkt &&
           (hdr_flags == cfg_version || hdr_flags == cfg_next);
  endfunction

  task automatic reset_tracker();
    cfg_magic = 24'h46524D;
    cfg_width = 16'd64;
    cfg_height = 16'd32;
    cfg_frame_limit = 16'd64;
    cfg_frame_len = 16'd4096;
    cfg_max_pkt = 24'd2097152;
    cfg_version = 8'd1;
    cfg_next = 8'd2;
    ph = RX_IDLE;
    sync_win = '0;
    byte_idx = '0;
    crc_acc = CrcInit;
    fill_slot = 1'b0;
    hdr_flags = '0;
    hdr_frames = '0;
    hdr_width = '0;
    hdr_height = '0;
    hdr_plen = '0;
    crc_hi = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    rx_event_t       r;
    logic [23:0]     pos;
    bit              emit;
    longint unsigned end_pos;
    pos = byte_idx;
    emit = 1'b1;
    r.ev = EV_STORED;
    r.data = b;
    r.off = pos;
    r.slot = fill_slot;
    r.frames = '0;
    case (ph)
      RX_HDR: begin
        case (pos)
          24'd3: hdr_flags = b;
          24'd4: hdr_frames = {b, 8'h00};
          24'd5: hdr_frames[7:0] = b;
          24'd6: hdr_width = {b, 8'h00};
          24'd7: hdr_width[7:0] = b;
          24'd8: hdr_height = {b, 8'h00};
          24'd9: hdr_height[7:0] = b;
          24'd12: hdr_plen = {24'h000000, b};
          24'd13, 24'd14, 24'd15: hdr_plen = {hdr_plen[23:0], b};
          default: ;
        endcase
        crc_acc = crc16_next(crc_acc, b);
        byte_idx = pos + 24'd1;
        if (byte_idx >= HdrLen) begin
          if (!header_ok()) begin
            ph = RX_IDLE;
            byte_idx = '0;
            r.ev = EV_ERR_HEADER;
            r.frames = hdr_frames;
          end else begin
            ph = (hdr_plen == 32'd0) ? RX_CRC_HI : RX_BODY;
          end
        end
      end
      RX_BODY: begin
        crc_acc = crc16_next(crc_acc, b);
        byte_idx = pos + 24'd1;
        end_pos = 64'(hdr_plen) + 64'(HdrLen);
        if (byte_idx >= end_pos) ph = RX_CRC_HI;
      end
      RX_CRC_HI: begin
        crc_hi = b;
        byte_idx = pos + 24'd1;
        ph = RX_CRC_LO;
      end
      RX_CRC_LO: begin
        ph = RX_IDLE;
        byte_idx = '0;
        r.frames = hdr_frames;
        if ({crc_hi, b} != crc_acc) begin
          r.ev = EV_NAK_CRC;
        end else if (hdr_flags == cfg_next) begin
          r.ev = EV_ACK_PRELOAD;
        end else begin
          r.ev = EV_ACK_COMMIT;
          fill_slot = ~fill_slot;
        end
      end
      default: begin
        ph = RX_IDLE;
        sync_win = {sync_win[15:0], b};
        emit = 1'b0;
        if (sync_win == cfg_magic) begin
          sync_win = '0;
          crc_acc = crc16_next(crc16_next(crc16_next(CrcInit, cfg_magic[23:16]),
                                          cfg_magic[15:8]), cfg_magic[7:0]);
          byte_idx = 24'd3;
          ph = RX_HDR;
          emit = 1'b1;
          r.ev = EV_START;
          r.off = '0;
        end
      end
    endcase
    if (emit) rx_events_due.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [23:0] want,
                                      input logic [23:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAGIC:       cfg_magic = val[23:0];
      REG_WIDTH:       cfg_width = val[15:0];
      REG_HEIGHT:      cfg_height = val[15:0];
      REG_FRAME_LIMIT: cfg_frame_limit = val[15:0];
      REG_FRAME_LEN:   cfg_frame_len = val[15:0];
      REG_MAX_PACKET:  cfg_max_pkt = val[23:0];
      REG_VERSION:     cfg_version = val[7:0];
      REG_NEXT:        cfg_next = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [23:0] magic, input logic [15:0] w,
                            input logic [15:0] h, input logic [15:0] mf,
                            input logic [15:0] flen, input logic [23:0] max_pkt,
                            input logic [7:0] ver, input logic [7:0] nxt);
    apb_write(REG_MAGIC, {8'd0, magic});
    apb_write(REG_WIDTH, {16'd0, w});
    apb_write(REG_HEIGHT, {16'd0, h});
    apb_write(REG_FRAME_LIMIT, {16'd0, mf});
    apb_write(REG_FRAME_LEN, {16'd0, flen});
    apb_write(REG_MAX_PACKET, {8'd0, max_pkt});
    apb_write(REG_VERSION, {24'd0, ver});
    apb_write(REG_NEXT, {24'd0, nxt});
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    byte_q.push_back(b);
  endfunction

  task automatic queue_packet(input logic [7:0] flags, input logic [15:0] frames,
                              input logic [15:0] w, input logic [15:0] h,
                              input logic [31:0] plen, input int unsigned body,
                              input bit with_crc, input bit bad_crc);
    logic [7:0]  hdr[HdrLen];
    logic [7:0]  b;
    logic [15:0] crc;
    for (int i = 0; i < HdrLen; i++) hdr[i] = 8'($urandom_range(255));
    hdr[0] = cfg_magic[23:16];
    hdr[1] = cfg_magic[15:8];
    hdr[2] = cfg_magic[7:0];
    hdr[3] = flags;
    hdr[4] = frames[15:8];
    hdr[5] = frames[7:0];
    hdr[6] = w[15:8];
    hdr[7] = w[7:0];
    hdr[8] = h[15:8];
    hdr[9] = h[7:0];
    hdr[12] = plen[31:24];
    hdr[13] = plen[23:16];
    hdr[14] = plen[15:8];
    hdr[15] = plen[7:0];
    crc = CrcInit;
    for (int i = 0; i < HdrLen; i++) begin
      queue_byte(hdr[i]);
      crc = crc16_next(crc, hdr[i]);
    end
    repeat (body) begin
      b = 8'($urandom_range(255));
      queue_byte(b);
      crc = crc16_next(crc, b);
    end
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
    if (with_crc) begin
      queue_byte(crc[15:8]);
      queue_byte(crc[7:0]);
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || rx_events_due.size() != 0) @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  framed_packet_receiver_crc16_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .event_res_o  (event_res),
    .data_byte_o  (data_byte),
    .offset_o     (offset),
    .slot_o       (slot),
    .frame_count_o(frame_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (rx_events_due.size() == 0) begin
          $error("result item with nothing expected: event_res %0d offset 'h%0h",
                 event_res, offset);
          fail_cnt++;
        end else begin
          due = rx_events_due.pop_front();
          check_field("event_res", 24'(due.ev), 24'(event_res));
          check_field("data_byte", 24'(due.data), 24'(data_byte));
          check_field("offset", due.off, offset);
          check_field("slot", 24'(due.slot), 24'(slot));
          check_field("frame_count", 24'(due.frames), 24'(frame_count));
        end
      end
      if (hold_arm && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    reset_tracker();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // register defaults: idle bytes, a restarted sync and a rejected header
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(cfg_magic[23:16]);
    queue_byte(cfg_magic[15:8]);
    queue_byte(cfg_magic[23:16]);
    queue_byte(cfg_magic[15:8]);
    queue_packet(cfg_version, 16'd0, cfg_width, cfg_height, 32'd0, 0, 1'b0, 1'b0);
    wait_drained();

    // commit with slot flip, preload, crc failure and bad flags behind a long output hold,
    // then a stretch with no idling on either side
    set_config(24'hA5C33C, 16'h0102, 16'h0304, 16'd4, 16'd3, 24'd91, 8'h11, 8'h22);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_arm = 1'b1;
    queue_packet(8'h11, 16'd2, 16'h0102, 16'h0304, 32'd6, 6, 1'b1, 1'b0);
    queue_packet(8'h22, 16'd3, 16'h0102, 16'h0304, 32'd9, 9, 1'b1, 1'b0);
    queue_packet(8'h11, 16'd1, 16'h0102, 16'h0304, 32'd3, 3, 1'b1, 1'b1);
    queue_packet(8'h33, 16'd1, 16'h0102, 16'h0304, 32'd3, 0, 1'b0, 1'b0);
    wait_drained();
    src_idle_pct = 17;
    sink_idle_pct = 17;

    // zero payload, flags equal to both version and next, 84-byte limit for an 82-byte packet
    set_config(24'hFFFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 24'd84, 8'hFF, 8'hFF);
    queue_packet(8'hFF, 16'hFFFF, 16'hFFFF, 16'h0000, 32'd0, 0, 1'b1, 1'b0);
    wait_drained();

    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout waiting for result items");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
